FILE: src/fed_pkg.sv
// Shared types and constants of the feedback echo delay block.
`default_nettype none

package fed_pkg;

	// Fixed-point constants
	localparam int FRAC_BITS = 8;
	localparam int Q_BITS    = 15;
	localparam int ROUND_Q8  = 128;
	localparam int ROUND_Q15 = 16384;
	localparam logic [14:0] FB_MAX = 15'd32440;
	localparam logic [16:0] UNITY  = 17'd32768;

	// Register map, word index on the APB port
	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_DELAY_WH = 3'd1,
		REG_DELAY_FR = 3'd2,
		REG_FEEDBACK = 3'd3,
		REG_WET      = 3'd4
	} reg_idx_t;

	// Configuration register contents
	typedef struct packed {
		logic        enable;
		logic [14:0] delay_whole;
		logic [7:0]  delay_fraction;
		logic [14:0] feedback_gain;
		logic [15:0] wet_gain;
	} cfg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_INTERP,
		ST_MIX,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd;
		logic interp;
		logic mix;
		logic finish;
		logic bypass;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: src/fed_regs.sv
// APB configuration registers of the feedback echo delay block.
`default_nettype none

module fed_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output fed_pkg::cfg_t cfg
);
	import fed_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access cycle of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable         <= 1'b1;
			cfg_q.delay_whole    <= '0;
			cfg_q.delay_fraction <= '0;
			cfg_q.feedback_gain  <= '0;
			cfg_q.wet_gain       <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE:   cfg_q.enable         <= pwdata[0];
				REG_DELAY_WH: cfg_q.delay_whole    <= pwdata[14:0];
				REG_DELAY_FR: cfg_q.delay_fraction <= pwdata[7:0];
				REG_FEEDBACK: cfg_q.feedback_gain  <= pwdata[14:0];
				REG_WET:      cfg_q.wet_gain       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE:   prdata = {31'b0, cfg_q.enable};
			REG_DELAY_WH: prdata = {17'b0, cfg_q.delay_whole};
			REG_DELAY_FR: prdata = {24'b0, cfg_q.delay_fraction};
			REG_FEEDBACK: prdata = {17'b0, cfg_q.feedback_gain};
			REG_WET:      prdata = {16'b0, cfg_q.wet_gain};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/fed_ctrl.sv
// Sequencing state machine of the feedback echo delay block.
`default_nettype none

module fed_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  fed_pkg::dp_stat_t stat,
	output fed_pkg::dp_cmd_t  cmd
);
	import fed_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   bypass_q;

	// State and bypass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bypass_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && sample_valid) begin
				bypass_q <= ~enable;
			end
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_nxt = enable ? ST_READ : ST_DONE;
				end
			end
			ST_READ:   state_nxt = ST_INTERP;
			ST_INTERP: state_nxt = ST_MIX;
			ST_MIX:    state_nxt = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		sample_ready = 1'b0;
		cmd          = '0;
		cmd.bypass   = bypass_q;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				cmd.load     = sample_valid;
			end
			ST_READ:   cmd.rd     = 1'b1;
			ST_INTERP: cmd.interp = 1'b1;
			ST_MIX:    cmd.mix    = 1'b1;
			ST_DONE:   cmd.finish = stat.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/fed_dp.sv
// Datapath of the feedback echo delay block: delay memory, interpolation, mix, feedback.
`default_nettype none

module fed_dp #(
	parameter int DELAY_DEPTH = 32768,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fed_pkg::cfg_t      cfg,
	input  fed_pkg::dp_cmd_t   cmd,
	output fed_pkg::dp_stat_t  stat,
	input  logic signed [15:0] sample_in,
	input  logic               channel,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] sample_out,
	output logic               channel_out
);
	import fed_pkg::*;

	localparam int S         = SAMPLE_BITS;
	localparam int AW        = $clog2(DELAY_DEPTH);
	localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_WORDS = 2 ** (CH_BITS + AW);
	localparam int D_MAX     = DELAY_DEPTH - 2;
	localparam int MX        = (S + 16 > 33) ? S + 16 : 33;
	localparam int WW        = ((S > 16) ? S : 16) + 2;

	// Captured input
	logic signed [15:0]   x_q;
	logic                 chin_q;
	logic [CH_BITS-1:0]   ch_q;

	// Per-channel write pointer and fill count
	logic [AW-1:0]        wp_q   [CHANNELS];
	logic [AW:0]          fill_q [CHANNELS];

	// Delay memory, no reset; entries beyond the fill count read as zero
	logic [S-1:0]         mem_q  [MEM_WORDS];

	logic [AW-1:0]        d_sel;
	logic [AW:0]          t_sum;
	logic [AW-1:0]        idx0;
	logic [AW-1:0]        idx1;
	logic [AW-1:0]        wp_cur;
	logic [AW:0]          fill_cur;

	logic [S-1:0]         rd0_s1;
	logic [S-1:0]         rd1_s1;
	logic                 ok0_s1;
	logic                 ok1_s1;

	logic signed [S-1:0]  y0;
	logic signed [S-1:0]  y1;
	logic signed [S:0]    diff;
	logic signed [S-1:0]  y0_s2;
	logic signed [S+9:0]  prod_s2;

	logic signed [S+9:0]  isum;
	logic signed [S-1:0]  v;
	logic [14:0]          fb;
	logic [16:0]          wet;
	logic [16:0]          dry;
	logic signed [32:0]   xd_s3;
	logic signed [S+15:0] vw_s3;
	logic signed [S+15:0] vf_s3;

	logic signed [MX-1:0] mix;
	logic signed [15:0]   mix_sat;
	logic signed [S+15:0] fsum;
	logic signed [WW-1:0] wsum;
	logic [S-1:0]         wr_data;

	logic                 out_valid_q;
	logic signed [15:0]   out_data_q;
	logic                 out_ch_q;

	assign wp_cur   = wp_q[ch_q];
	assign fill_cur = fill_q[ch_q];

	// Read positions: D and D+1 samples behind the write pointer
	always_comb begin
		if ({17'b0, cfg.delay_whole} > 32'(D_MAX)) begin
			d_sel = AW'(D_MAX);
		end else begin
			d_sel = AW'(cfg.delay_whole);
		end
		t_sum = {1'b0, wp_cur} + (AW + 1)'(DELAY_DEPTH) - {1'b0, d_sel};
		if (t_sum >= (AW + 1)'(DELAY_DEPTH)) begin
			idx0 = AW'(t_sum - (AW + 1)'(DELAY_DEPTH));
		end else begin
			idx0 = t_sum[AW-1:0];
		end
		if (idx0 == '0) begin
			idx1 = AW'(DELAY_DEPTH - 1);
		end else begin
			idx1 = idx0 - 1'b1;
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample_in;
			chin_q <= channel;
			ch_q   <= (CHANNELS > 1) ? CH_BITS'(channel) : '0;
		end
	end

	// Memory write and registered reads
	always_ff @(posedge clk) begin
		if (cmd.finish && !cmd.bypass) begin
			mem_q[{ch_q, wp_cur}] <= wr_data;
		end
		if (cmd.rd) begin
			rd0_s1 <= mem_q[{ch_q, idx0}];
			rd1_s1 <= mem_q[{ch_q, idx1}];
			ok0_s1 <= fill_cur > {1'b0, idx0};
			ok1_s1 <= fill_cur > {1'b0, idx1};
		end
	end

	// Pointer and fill count per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.finish && !cmd.bypass) begin
			wp_q[ch_q] <= (wp_cur == AW'(DELAY_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
			if (fill_cur != (AW + 1)'(DELAY_DEPTH)) begin
				fill_q[ch_q] <= fill_cur + 1'b1;
			end
		end
	end

	// Interpolation product
	assign y0   = ok0_s1 ? $signed(rd0_s1) : '0;
	assign y1   = ok1_s1 ? $signed(rd1_s1) : '0;
	assign diff = (S + 1)'(y1) - (S + 1)'(y0);

	always_ff @(posedge clk) begin
		if (cmd.interp) begin
			y0_s2   <= y0;
			prod_s2 <= (S + 10)'(diff) * (S + 10)'($signed({1'b0, cfg.delay_fraction}));
		end
	end

	// Interpolated value and the three gain products
	assign isum = $signed({{2{y0_s2[S-1]}}, y0_s2, {FRAC_BITS{1'b0}}}) + prod_s2
		+ (S + 10)'(ROUND_Q8);
	assign v    = isum[S+FRAC_BITS-1:FRAC_BITS];
	assign fb   = (cfg.feedback_gain > FB_MAX) ? FB_MAX : cfg.feedback_gain;
	assign wet  = ({1'b0, cfg.wet_gain} > UNITY) ? UNITY : {1'b0, cfg.wet_gain};
	assign dry  = UNITY - wet;

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			xd_s3 <= 33'(x_q) * 33'($signed(dry));
			vw_s3 <= (S + 16)'(v) * (S + 16)'($signed(wet));
			vf_s3 <= (S + 16)'(v) * (S + 16)'($signed({1'b0, fb}));
		end
	end

	// Output mix, rounded and saturated to 16 bits
	always_comb begin
		mix = MX'(xd_s3) + MX'(vw_s3) + MX'(ROUND_Q15);
		if (mix[MX-1:Q_BITS+15] == '0 || mix[MX-1:Q_BITS+15] == '1) begin
			mix_sat = mix[Q_BITS+15:Q_BITS];
		end else if (mix[MX-1]) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = 16'sh7FFF;
		end
	end

	// Feedback write value, saturated to the memory width
	always_comb begin
		fsum = vf_s3 + (S + 16)'(ROUND_Q15);
		wsum = WW'(x_q) + WW'($signed(fsum[S+Q_BITS:Q_BITS]));
		if (wsum[WW-1:S-1] == '0 || wsum[WW-1:S-1] == '1) begin
			wr_data = wsum[S-1:0];
		end else if (wsum[WW-1]) begin
			wr_data = {1'b1, {(S - 1){1'b0}}};
		end else begin
			wr_data = {1'b0, {(S - 1){1'b1}}};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= cmd.bypass ? x_q : mix_sat;
			out_ch_q   <= chin_q;
		end
	end

	assign stat.out_free = ~out_valid_q | result_ready;
	assign result_valid  = out_valid_q;
	assign sample_out    = out_data_q;
	assign channel_out   = out_ch_q;

endmodule

`default_nettype wire

FILE: src/feedback_echo_delay.sv
// Feedback echo delay: top level joining registers, controller and datapath.
//
// Input channel (sample_valid/sample_ready) carries one Q1.15 sample and its
// channel number; the result channel (result_valid/result_ready) returns the
// mixed sample and the same channel number, one result per input, in order.
// Settings are to be written over the APB port only while no item is in
// flight; the block itself does not enforce it. With the echo enabled an
// item goes through capture, memory read, interpolation multiply, gain
// multiplies and write-back with the output register, in order; the next item
// is taken only after that, as the single shared memory access and multiply
// sequence serves one item at a time. Disabled, capture feeds the output
// register, where the result sits; a new item is taken while it waits, and
// a stalled receiver holds the sequencer at its last step until taken.
// Reset clears pointers and fill counts; memory entries not yet written read
// as zero, so there is no clearing pass and the block is ready at once.
`default_nettype none

module feedback_echo_delay #(
	parameter int DELAY_DEPTH = 32768,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [15:0] sample_in,
	input  logic               channel,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] sample_out,
	output logic               channel_out
);
	import fed_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	fed_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fed_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable       (cfg.enable),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	fed_dp #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.sample_in    (sample_in),
		.channel      (channel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_out   (sample_out),
		.channel_out  (channel_out)
	);

endmodule

`default_nettype wire

FILE: src/fed_checker.sv
// Port-level checks of the feedback echo delay block, bound to the top level.
`default_nettype none

module fed_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [15:0] sample_out,
	input logic               channel_out
);

	logic [2:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = sample_valid & sample_ready;
	assign out_xfer = result_valid & result_ready;

	// Items taken but not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, in_xfer} - {2'b0, out_xfer};
		end
	end

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(sample_out)
			&& $stable(channel_out))
		else $error("stalled result changed");

	// One item in work at a time: ready drops after a transfer
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !sample_ready)
		else $error("input taken while busy");

	// No result without a pending item
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 3'd0)
		else $error("result without input");

	// At most one waiting result and one in work
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("too many items in flight");

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.sample_out   (sample_out),
	.channel_out  (channel_out)
);

`default_nettype wire
